// ===== sv/slid_pkg.sv =====
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and constants of the sorted list insert/delete core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slid_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 7;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                    kind;
        logic signed [KEY_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ECNT_W-1:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic sample;
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== sv/sorted_list_insert_delete_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_core
// Bounded ascending multiset of signed 32-bit keys kept in a chain of cells;
// insert places a key in order, delete removes one equal key.
//
//   channel  dir  handshake                 word
//   input    in   i_in_valid / o_in_ready   t_in_word  (kind, value)
//   output   out  o_out_valid / i_out_ready t_out_word (status, entry_count)
//
// An item passes through three steps: accept, compare in every cell, then shift.
// The shift waits while the previous result is still held in the output
// register; the input side is ready again right after the shift.
// Reset clears the entry count and the handshake state; entries need none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_delete_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire slid_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output slid_pkg::t_out_word      o_out_word
);
    import slid_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_kind;
    logic signed [KEY_W-1:0] r_key;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out_word, n_out_word;

    logic                    w_in_acc;
    logic                    w_go;
    logic                    w_full;
    logic                    w_found;
    t_cell_ctrl              w_ctrl;

    logic signed [KEY_W-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0]     w_after;
    logic [CAPACITY-1:0]     w_ge;
    logic [CAPACITY-1:0]     w_hit;
    logic [CAPACITY-1:0]     w_occ;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_go       = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);
    assign w_full     = (r_count >= CNT_W'(CAPACITY));
    assign w_found    = |w_hit;

    always_comb begin
        w_ctrl.sample = (r_state == S_CMP);
        w_ctrl.ins    = w_go && (r_kind == KIND_INSERT) && !w_full;
        w_ctrl.del    = w_go && (r_kind == KIND_DELETE) && w_found;
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [KEY_W-1:0] w_prev_entry;
        logic signed [KEY_W-1:0] w_next_entry;
        logic                    w_prev_after;
        logic                    w_prev_ge;

        assign w_occ[gi] = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_head
            assign w_prev_entry = r_key;
            assign w_prev_after = 1'b0;
            assign w_prev_ge    = 1'b0;
        end else begin : g_body
            assign w_prev_entry = w_entry[gi-1];
            assign w_prev_after = w_after[gi-1];
            assign w_prev_ge    = w_ge[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_next_entry = w_entry[gi];
        end else begin : g_mid
            assign w_next_entry = w_entry[gi+1];
        end

        slid_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occ        (w_occ[gi]),
            .i_key        (r_key),
            .i_prev_entry (w_prev_entry),
            .i_next_entry (w_next_entry),
            .i_prev_after (w_prev_after),
            .i_prev_ge    (w_prev_ge),
            .o_entry      (w_entry[gi]),
            .o_after      (w_after[gi]),
            .o_ge         (w_ge[gi]),
            .o_hit        (w_hit[gi])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_kind == KIND_INSERT) begin
                        if (w_full) begin
                            n_out_word.status = ST_FULL;
                        end else begin
                            n_out_word.status = ST_DONE;
                            n_count           = r_count + CNT_W'(1);
                        end
                    end else begin
                        if (w_found) begin
                            n_out_word.status = ST_DONE;
                            n_count           = r_count - CNT_W'(1);
                        end else begin
                            n_out_word.status = ST_NOT_FOUND;
                        end
                    end
                    n_out_word.entry_count = ECNT_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= i_in_word.kind;
            r_key  <= i_in_word.value;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_CMP))
        else $error("accepted word did not start compare");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == ST_DONE ||
                         o_out_word.status == ST_NOT_FOUND ||
                         o_out_word.status == ST_FULL))
        else $error("illegal status code");

    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $onehot0(w_hit))
        else $error("more than one delete match");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_go) |-> (r_count == $past(r_count) ||
                         r_count == $past(r_count) + CNT_W'(1) ||
                         r_count + CNT_W'(1) == $past(r_count)))
        else $error("entry count moved by more than one");

endmodule

`default_nettype wire

// ===== sv/slid_cell.sv =====
// ----------------------------------------------------------------------------
// slid_cell
// One slot of the sorted chain: holds an entry, compares it with the key and
// takes its neighbor's entry or the key when the chain shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slid_cell (
    input  wire logic                             i_clk,
    input  wire slid_pkg::t_cell_ctrl             i_ctrl,
    input  wire logic                             i_occ,
    input  wire logic signed [slid_pkg::KEY_W-1:0] i_key,
    input  wire logic signed [slid_pkg::KEY_W-1:0] i_prev_entry,
    input  wire logic signed [slid_pkg::KEY_W-1:0] i_next_entry,
    input  wire logic                             i_prev_after,
    input  wire logic                             i_prev_ge,
    output logic signed [slid_pkg::KEY_W-1:0]      o_entry,
    output logic                                  o_after,
    output logic                                  o_ge,
    output logic                                  o_hit
);
    import slid_pkg::*;

    logic signed [KEY_W-1:0] r_entry;
    logic                    r_after;
    logic                    r_ge;
    logic                    r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sample) begin
            r_after <= !i_occ || (r_entry > i_key);
            r_ge    <= !i_occ || (r_entry >= i_key);
            r_eq    <= i_occ && (r_entry == i_key);
        end
        if (i_ctrl.ins && r_after) begin
            r_entry <= i_prev_after ? i_prev_entry : i_key;
        end else if (i_ctrl.del && r_ge) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_after = r_after;
    assign o_ge    = r_ge;
    // first entry not below the key, and equal to it
    assign o_hit   = r_eq && r_ge && !i_prev_ge;

endmodule

`default_nettype wire
